// ----- hdl/paged_frame_allocator_top_macros.svh -----
// Assertion macros for the paged frame allocator.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef PAGED_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define PAGED_FRAME_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfa: same-cycle check failed");
`define PFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfa: next-cycle check failed");
`else
`define PFA_ASSERT_IMP(lbl, ante, cons)
`define PFA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/pfa_pkg.sv -----
// Shared types and constants for the paged frame allocator.
// No dependencies.
package pfa_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SIZE_W   = 20;
  localparam int unsigned PID_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FIDX_W   = 8;
  localparam int unsigned POFF_W   = 12;
  localparam int unsigned PAGE_W   = 13;
  localparam int unsigned FCNT_W   = 9;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PAGE_W-1:0] PAGE_MAX       = PAGE_W'(4096);
  localparam logic [PAGE_W-1:0] PAGE_RESET     = PAGE_W'(256);
  localparam logic [FCNT_W-1:0] FCNT_RESET     = FCNT_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_DELETE = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOMEM    = 3'd1,
    ST_NOPROC   = 3'd2,
    ST_NOBYTE   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_NOIDS    = 3'd5
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;     // clearing pass, one frame per cycle
    logic accept;    // latch request word
    logic decide;    // evaluate checks that need no scan
    logic scan;      // walk the frame table
    logic load_out;  // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic early;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/pfa_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pfa_ctrl.sv -----
// Sequencer for the paged frame allocator: clear pass, decide, scan, finish.
// Depends on pfa_pkg.
module pfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  pfa_pkg::sts_t sts_i,
  output pfa_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   stall_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.clear    = (state_q == S_CLEAR);
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i && !stall_q;
    cmd_o.decide   = (state_q == S_DECIDE);
    cmd_o.scan     = (state_q == S_SCAN);
    cmd_o.load_out = (state_q == S_FINISH) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      stall_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid_i && !stall_q) begin
            state_q <= S_DECIDE;
            stall_q <= 1'b1;
          end
        end
        S_DECIDE: begin
          state_q <= sts_i.early ? S_FINISH : S_SCAN;
        end
        S_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_CLEAR;
          stall_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_stall_o = stall_q;

endmodule

// ----- hdl/pfa_dp.sv -----
// Datapath: config registers, frame owner and size tables, scan pipeline, result register.
// Depends on pfa_pkg and pfa_ram.
module pfa_dp #(
  parameter int unsigned MaxFrames = 256,
  parameter int unsigned MaxProcs  = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pfa_pkg::cmd_t                      cmd_i,
  output pfa_pkg::sts_t                      sts_o,
  input  logic                               cfg_valid_i,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pfa_pkg::PAGE_W-1:0]         cfg_data_i,
  input  logic [pfa_pkg::FUNC_W-1:0]         func_i,
  input  logic [pfa_pkg::SIZE_W-1:0]         proc_size_i,
  input  logic [pfa_pkg::PID_W-1:0]          proc_id_i,
  input  logic [pfa_pkg::SIZE_W-1:0]         byte_num_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [pfa_pkg::STATUS_W-1:0]       status_o,
  output logic [pfa_pkg::PID_W-1:0]          assigned_id_o,
  output logic [pfa_pkg::FIDX_W-1:0]         frame_index_o,
  output logic [pfa_pkg::POFF_W-1:0]         page_offset_o
);

  localparam int unsigned FaW  = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int unsigned FcW  = $clog2(MaxFrames + 1);
  localparam int unsigned OwnW = $clog2(MaxProcs);
  localparam int unsigned IdW  = $clog2(MaxProcs + 1);
  localparam int unsigned SzW  = pfa_pkg::SIZE_W;

  // config
  logic [pfa_pkg::PAGE_W-1:0] page_size_q;
  logic [pfa_pkg::FCNT_W-1:0] frame_count_q;
  logic [pfa_pkg::PAGE_W-1:0] pg_eff;
  logic [SzW-1:0]             pg;
  logic [FcW-1:0]             nf;

  // request
  logic [pfa_pkg::FUNC_W-1:0] op_q;
  logic [OwnW-1:0]            pid_q;
  logic                       pid_ok_q;
  logic                       ids_out_q;
  logic [SzW-1:0]             byte_q;
  logic [IdW-1:0]             next_id_q;
  logic [IdW-1:0]             id_q;

  // scan
  logic [FcW-1:0]  rd_idx_q, rd_idx_d;
  logic            chk_vld_q, chk_vld_d;
  logic [FaW-1:0]  chk_idx_q;
  logic [SzW-1:0]  left_q, left_d;
  logic [SzW-1:0]  rem_q, rem_d;
  logic            hit_q, hit_d;
  logic [FaW-1:0]  fidx_q, fidx_d;
  logic [pfa_pkg::POFF_W-1:0] poff_q, poff_d;
  logic            stop_now, issue, proc_en;

  // decisions
  logic                         early_q;
  logic [pfa_pkg::STATUS_W-1:0] early_st_q;
  logic                         early;
  logic [pfa_pkg::STATUS_W-1:0] early_st, scan_st, final_st;

  // RAM ports
  logic            own_we;
  logic [FaW-1:0]  own_waddr;
  logic [OwnW-1:0] own_wdata;
  logic [OwnW-1:0] own_rdata;
  logic            size_we;
  logic [SzW-1:0]  size_rdata;

  // output register
  logic                         out_valid_q;
  logic [pfa_pkg::STATUS_W-1:0] status_q;
  logic [pfa_pkg::PID_W-1:0]    aid_q;
  logic [pfa_pkg::FIDX_W-1:0]   fout_q;
  logic [pfa_pkg::POFF_W-1:0]   pout_q;

  // effective page size and frame count
  always_comb begin
    if (page_size_q == '0) begin
      pg_eff = pfa_pkg::PAGE_W'(1);
    end else if (page_size_q > pfa_pkg::PAGE_MAX) begin
      pg_eff = pfa_pkg::PAGE_MAX;
    end else begin
      pg_eff = page_size_q;
    end
  end
  assign pg = SzW'(pg_eff);
  assign nf = (32'(frame_count_q) > 32'(MaxFrames)) ? FcW'(MaxFrames) : FcW'(frame_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q   <= pfa_pkg::PAGE_RESET;
      frame_count_q <= pfa_pkg::FCNT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pfa_pkg::CFG_PAGE_SIZE:   page_size_q   <= cfg_data_i;
        pfa_pkg::CFG_FRAME_COUNT: frame_count_q <= cfg_data_i[pfa_pkg::FCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // scan control
  assign stop_now = ((op_q == pfa_pkg::FUNC_INSERT) && (left_q == '0)) ||
                    ((op_q == pfa_pkg::FUNC_FIND) && hit_q);
  assign issue    = cmd_i.scan && !stop_now && (rd_idx_q < nf);
  assign proc_en  = cmd_i.scan && chk_vld_q && !stop_now;

  always_comb begin
    rd_idx_d  = rd_idx_q;
    chk_vld_d = chk_vld_q;
    left_d    = left_q;
    rem_d     = rem_q;
    hit_d     = hit_q;
    fidx_d    = fidx_q;
    poff_d    = poff_q;
    own_we    = 1'b0;
    own_waddr = chk_idx_q;
    own_wdata = '0;
    if (cmd_i.clear) begin
      rd_idx_d  = rd_idx_q + FcW'(1);
      own_we    = 1'b1;
      own_waddr = rd_idx_q[FaW-1:0];
    end else if (cmd_i.accept) begin
      rd_idx_d  = '0;
      chk_vld_d = 1'b0;
      left_d    = proc_size_i;
      rem_d     = byte_num_i - SzW'(1);
      hit_d     = 1'b0;
      fidx_d    = '0;
      poff_d    = '0;
    end else if (cmd_i.scan) begin
      chk_vld_d = issue;
      if (issue) begin
        rd_idx_d = rd_idx_q + FcW'(1);
      end
      if (proc_en) begin
        case (op_q)
          pfa_pkg::FUNC_INSERT: begin
            if (own_rdata == '0) begin
              own_we    = 1'b1;
              own_wdata = OwnW'(id_q);
              left_d    = (left_q > pg) ? (left_q - pg) : '0;
            end
          end
          pfa_pkg::FUNC_FIND: begin
            if (own_rdata == pid_q) begin
              if (rem_q < pg) begin
                hit_d  = 1'b1;
                fidx_d = chk_idx_q;
                poff_d = rem_q[pfa_pkg::POFF_W-1:0];
              end else begin
                rem_d = rem_q - pg;
              end
            end
          end
          pfa_pkg::FUNC_DELETE: begin
            if (own_rdata == pid_q) begin
              own_we = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      next_id_q <= IdW'(1);
    end else begin
      rd_idx_q  <= rd_idx_d;
      chk_vld_q <= chk_vld_d;
      if (cmd_i.accept && (func_i == pfa_pkg::FUNC_INSERT) &&
          (next_id_q < IdW'(MaxProcs))) begin
        next_id_q <= next_id_q + IdW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= rd_idx_q[FaW-1:0];
    left_q    <= left_d;
    rem_q     <= rem_d;
    hit_q     <= hit_d;
    fidx_q    <= fidx_d;
    poff_q    <= poff_d;
    if (cmd_i.accept) begin
      op_q      <= func_i;
      pid_q     <= OwnW'(proc_id_i);
      pid_ok_q  <= (proc_id_i != '0) && (32'(proc_id_i) < 32'(next_id_q));
      ids_out_q <= (next_id_q >= IdW'(MaxProcs));
      byte_q    <= byte_num_i;
      id_q      <= next_id_q;
    end
    if (cmd_i.decide) begin
      early_q    <= early;
      early_st_q <= early_st;
    end
  end

  // checks that settle without a scan; size read data is valid in the decide cycle
  always_comb begin
    early    = 1'b0;
    early_st = pfa_pkg::ST_OK;
    case (op_q)
      pfa_pkg::FUNC_INSERT: begin
        early    = ids_out_q;
        early_st = pfa_pkg::ST_NOIDS;
      end
      pfa_pkg::FUNC_FIND: begin
        if (!pid_ok_q) begin
          early    = 1'b1;
          early_st = pfa_pkg::ST_NOPROC;
        end else if ((byte_q == '0) || (byte_q > size_rdata)) begin
          early    = 1'b1;
          early_st = pfa_pkg::ST_NOBYTE;
        end
      end
      pfa_pkg::FUNC_DELETE: begin
        early    = !pid_ok_q;
        early_st = pfa_pkg::ST_NOPROC;
      end
      default: early = 1'b1;
    endcase
  end

  always_comb begin
    case (op_q)
      pfa_pkg::FUNC_INSERT: scan_st = (left_q == '0) ? pfa_pkg::ST_OK : pfa_pkg::ST_NOMEM;
      pfa_pkg::FUNC_FIND:   scan_st = hit_q ? pfa_pkg::ST_OK : pfa_pkg::ST_NOTFOUND;
      default:              scan_st = pfa_pkg::ST_OK;
    endcase
  end
  assign final_st = early_q ? early_st_q : scan_st;

  pfa_ram #(
    .Width (OwnW),
    .Depth (MaxFrames)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .raddr_i (rd_idx_q[FaW-1:0]),
    .rdata_o (own_rdata)
  );

  assign size_we = cmd_i.accept && (func_i == pfa_pkg::FUNC_INSERT) &&
                   (next_id_q < IdW'(MaxProcs));

  pfa_ram #(
    .Width (SzW),
    .Depth (MaxProcs)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (next_id_q[OwnW-1:0]),
    .wdata_i (proc_size_i),
    .raddr_i (OwnW'(proc_id_i)),
    .rdata_o (size_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q <= final_st;
      aid_q    <= ((op_q == pfa_pkg::FUNC_INSERT) && !ids_out_q) ?
                  pfa_pkg::PID_W'(id_q) : '0;
      if ((op_q == pfa_pkg::FUNC_FIND) && (final_st == pfa_pkg::ST_OK)) begin
        fout_q <= pfa_pkg::FIDX_W'(fidx_q);
        pout_q <= poff_q;
      end else begin
        fout_q <= '0;
        pout_q <= '0;
      end
    end
  end

  assign sts_o.clear_last = (rd_idx_q == FcW'(MaxFrames - 1));
  assign sts_o.early      = early;
  assign sts_o.scan_done  = stop_now || ((rd_idx_q >= nf) && !chk_vld_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign assigned_id_o = aid_q;
  assign frame_index_o = fout_q;
  assign page_offset_o = pout_q;

endmodule

// ----- hdl/paged_frame_allocator_top.sv -----
// Paged frame allocator: frame ownership table with insert, find and delete requests.
// Depends on pfa_pkg, pfa_ctrl, pfa_dp (with pfa_ram), paged_frame_allocator_top_macros.svh.
//
// Channels: request words (func, proc_size, proc_id, byte_num) enter on in_valid_i and
// are taken at an edge with in_valid_i high and in_stall_o low. One result word
// (status, assigned_id, frame_index, page_offset) leaves per request on out_valid_o and
// is taken when out_stall_i is low. Config writes (page_size at index 0, frame_count at
// index 1) go on cfg_valid_i/cfg_ready_o; the user is to make them only while no
// request is in flight, which the block does not enforce. Timing: one request at a
// time. A request settled by its checks alone (id exhausted, bad id, bad byte, unused
// func) skips the scan and goes from its decide step to its finish step. A request that
// walks the frame table reads one frame per cycle from the single owner RAM read port,
// up to frame_count frames; insert and find may end the scan early. A new request is
// taken the cycle after the result is registered, even while that result still waits
// on the receiver. Reset: the owner table is cleared by a pass over all MaxFrames
// frames, one frame per cycle, during which in_stall_o stays high; config writes are
// taken as ever. Process ids restart at one. Stall: while out_stall_i holds the result,
// a finished second request waits in its last step until the output register frees.
`include "paged_frame_allocator_top_macros.svh"

module paged_frame_allocator_top #(
  parameter int unsigned MaxFrames = 256,
  parameter int unsigned MaxProcs  = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pfa_pkg::FUNC_W-1:0]         func_i,
  input  logic [pfa_pkg::SIZE_W-1:0]         proc_size_i,
  input  logic [pfa_pkg::PID_W-1:0]          proc_id_i,
  input  logic [pfa_pkg::SIZE_W-1:0]         byte_num_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pfa_pkg::STATUS_W-1:0]       status_o,
  output logic [pfa_pkg::PID_W-1:0]          assigned_id_o,
  output logic [pfa_pkg::FIDX_W-1:0]         frame_index_o,
  output logic [pfa_pkg::POFF_W-1:0]         page_offset_o,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pfa_pkg::PAGE_W-1:0]         cfg_data_i
);

  pfa_pkg::cmd_t cmd;
  pfa_pkg::sts_t sts;

  // config registers always take a write
  assign cfg_ready_o = 1'b1;

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  pfa_dp #(
    .MaxFrames (MaxFrames),
    .MaxProcs  (MaxProcs)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .func_i        (func_i),
    .proc_size_i   (proc_size_i),
    .proc_id_i     (proc_id_i),
    .byte_num_i    (byte_num_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .assigned_id_o (assigned_id_o),
    .frame_index_o (frame_index_o),
    .page_offset_o (page_offset_o)
  );

  // a result is never loaded over one the receiver still holds
  `PFA_ASSERT_IMP(a_no_overwrite, cmd.load_out, !(out_valid_o && out_stall_i))
  // a loaded result shows up on the port next cycle
  `PFA_ASSERT_NXT(a_load_shows, cmd.load_out, out_valid_o)
  // one request at a time: busy right after taking a word
  `PFA_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // frame and offset only travel with a good status
  `PFA_ASSERT_IMP(a_loc_only_ok, out_valid_o && (status_o != pfa_pkg::ST_OK), (frame_index_o == '0) && (page_offset_o == '0))

endmodule
